### rtl/lr_pkg.sv
// shared types and constants of the line rasterizer
package lr_pkg;

   localparam int COORD_W        = 6;
   localparam int COLOR_W        = 24;
   localparam int ERR_W          = 8;
   localparam int GRID_SIZE_DEF  = 64;
   localparam int COLOR_BITS_DEF = 24;
   localparam int QUEUE_DEPTH    = 2;
   localparam int REQ_DATA_W     = 48;
   localparam int RSP_PAYLOAD_W  = 2 * COORD_W + COLOR_W;
   localparam int RSP_DATA_W     = 40;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic signed [ERR_W-1:0] err_type;

   // one classified line command
   typedef struct packed {
      coord_type row;
      coord_type col;
      coord_type trow;
      coord_type tcol;
      coord_type span_row;
      coord_type span_col;
      logic      dec_row;
      logic      dec_col;
      err_type   err;
      color_type color;
   } cmd_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic can_push;
      logic can_pop;
   } qstat_type;

endpackage

### rtl/lr_front.sv
// front end: takes a command, clamps it and works out spans, directions and start error
module lr_front #(
   parameter int GRID_SIZE  = lr_pkg::GRID_SIZE_DEF,
   parameter int COLOR_BITS = lr_pkg::COLOR_BITS_DEF
) (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  lr_pkg::qstat_type             qstat,
   output logic                          push,
   output lr_pkg::cmd_type               push_cmd
);
   import lr_pkg::*;

   localparam coord_type COORD_MAX = coord_type'(GRID_SIZE - 1);
   localparam color_type COLOR_MASK = (COLOR_BITS >= COLOR_W) ? {COLOR_W{1'b1}} :
                                      COLOR_W'((64'd1 << COLOR_BITS) - 64'd1);

   coord_type s_row, s_col, e_row, e_col;
   coord_type sr, sc;
   logic [ERR_W-1:0] half_row, half_col;

   function automatic coord_type clamp(input coord_type v);
      clamp = (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   always_comb begin
      s_row = clamp(req_tdata[COORD_W-1:0]);
      s_col = clamp(req_tdata[2*COORD_W-1:COORD_W]);
      e_row = clamp(req_tdata[3*COORD_W-1:2*COORD_W]);
      e_col = clamp(req_tdata[4*COORD_W-1:3*COORD_W]);

      sr = (s_row > e_row) ? s_row - e_row : e_row - s_row;
      sc = (s_col > e_col) ? s_col - e_col : e_col - s_col;
      half_row = ERR_W'(sr >> 1);
      half_col = ERR_W'(sc >> 1);

      push_cmd.row      = s_row;
      push_cmd.col      = s_col;
      push_cmd.trow     = e_row;
      push_cmd.tcol     = e_col;
      push_cmd.span_row = sr;
      push_cmd.span_col = sc;
      push_cmd.dec_row  = !(s_row < e_row);
      push_cmd.dec_col  = !(s_col < e_col);
      // start error: half the row span when rows dominate, else minus half the column span
      push_cmd.err      = (sr > sc) ? $signed(half_row) : $signed(-half_col);
      push_cmd.color    = req_tdata[4*COORD_W+COLOR_W-1:4*COORD_W] & COLOR_MASK;
   end

   assign req_tready = qstat.can_push;
   assign push       = req_tvalid && qstat.can_push;

endmodule

### rtl/lr_queue.sv
// short command queue between front and back
module lr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lr_pkg::cmd_type   push_cmd,
   input  logic              pop,
   output lr_pkg::cmd_type   pop_cmd,
   output lr_pkg::qstat_type qstat
);
   import lr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign qstat.can_push = (count_ff != CNT_FULL);
   assign qstat.can_pop  = (count_ff != '0);
   assign pop_cmd        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/lr_back.sv
// back end: steps the error term one pixel a cycle, while the output register is free or taken, into it
module lr_back #(
   parameter int GRID_SIZE = lr_pkg::GRID_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lr_pkg::qstat_type qstat,
   input  lr_pkg::cmd_type   pop_cmd,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output lr_pkg::coord_type out_row,
   output lr_pkg::coord_type out_col,
   output lr_pkg::color_type out_color,
   output logic              out_last
);
   import lr_pkg::*;

   localparam int CNT_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRID_SIZE - 1);

   cmd_type          line_ff, line_in;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   coord_type        row_ff, row_in, col_ff, col_in;
   color_type        color_ff, color_in;
   logic             last_ff, last_in;

   logic    emit, done, row_step, col_step;
   err_type dr, dc;

   assign pop  = !busy_ff && qstat.can_pop;
   assign emit = busy_ff && (!valid_ff || out_ready);
   assign done = (line_ff.row == line_ff.trow) && (line_ff.col == line_ff.tcol);

   always_comb begin
      dr       = $signed(ERR_W'(line_ff.span_row));
      dc       = $signed(ERR_W'(line_ff.span_col));
      row_step = line_ff.err > -dr;
      col_step = line_ff.err < dc;

      line_in  = line_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      valid_in = (out_ready) ? 1'b0 : valid_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      color_in = color_ff;
      last_in  = last_ff;

      if (pop) begin
         line_in = pop_cmd;
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (emit) begin
         valid_in = 1'b1;
         row_in   = line_ff.row;
         col_in   = line_ff.col;
         color_in = line_ff.color;
         last_in  = done;
         if (done || cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            line_in.err = line_ff.err - (row_step ? dc : err_type'(0))
                                      + (col_step ? dr : err_type'(0));
            if (row_step) begin
               line_in.row = line_ff.dec_row ? line_ff.row - 1'b1 : line_ff.row + 1'b1;
            end
            if (col_step) begin
               line_in.col = line_ff.dec_col ? line_ff.col - 1'b1 : line_ff.col + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff  <= line_in;
      cnt_ff   <= cnt_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_row   = row_ff;
   assign out_col   = col_ff;
   assign out_color = color_ff;
   assign out_last  = last_ff;

endmodule

### rtl/line_rasterizer.sv
// top level of the line rasterizer: front end, command queue and stepping back end
//
// channel  direction  contents
// req_     in         one line command: start point, end point, color
// rsp_     out        one pixel: position and color, tlast on the end point
//
// a line of n pixels leaves at one pixel a cycle while rsp_ is not stalled, once the
// command is loaded into the stepper; n is at most GRID_SIZE
// the error-term stepper in the back end sets that rate; the front end keeps taking
// commands while the two-entry queue has room, so the next line is ready on finish
// reset is synchronous and clears the queue, the stepper busy flag and the output valid
// a stall on rsp_ holds the pixel in the output register and pauses the stepper, not the intake
module line_rasterizer #(
   parameter int GRID_SIZE  = lr_pkg::GRID_SIZE_DEF,
   parameter int COLOR_BITS = lr_pkg::COLOR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // start_row, start_col, end_row, end_col, draw_color
   input  logic [lr_pkg::REQ_DATA_W-1:0] req_tdata,
   // pixel channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // pixel_row, pixel_col, pixel_color, zero padding
   output logic [lr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // last_pixel
   output logic                          rsp_tlast
);
   import lr_pkg::*;

   qstat_type qstat;
   cmd_type   push_cmd, pop_cmd;
   logic      push, pop;
   coord_type out_row, out_col;
   color_type out_color;

   // classify and clamp incoming commands
   lr_front #(
      .GRID_SIZE  (GRID_SIZE),
      .COLOR_BITS (COLOR_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // decouples command intake from pixel stepping
   lr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .qstat    (qstat)
   );

   // bresenham stepper with registered pixel output
   lr_back #(
      .GRID_SIZE (GRID_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_row   (out_row),
      .out_col   (out_col),
      .out_color (out_color),
      .out_last  (rsp_tlast)
   );

   // pack pixel fields lowest first, pad to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W-RSP_PAYLOAD_W){1'b0}}, out_color, out_col, out_row};

endmodule

### rtl/lr_checker.sv
// port-level checks on the line rasterizer and the bind that attaches them
module lr_checker #(
   parameter int GRID_SIZE = lr_pkg::GRID_SIZE_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [lr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                          rsp_tlast
);
   import lr_pkg::*;

   localparam coord_type COORD_MAX = coord_type'(GRID_SIZE - 1);

   // a stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("pixel changed while stalled");

   // no pixel straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("pixel valid after reset");

   // within a line the next pixel follows in the next cycle
   a_line_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a line");

   // pixels stay on the tile and padding is zero
   a_on_tile: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[COORD_W-1:0] <= COORD_MAX
                  && rsp_tdata[2*COORD_W-1:COORD_W] <= COORD_MAX
                  && rsp_tdata[RSP_DATA_W-1:RSP_PAYLOAD_W] == '0)
      else $error("pixel off the tile or padding set");

endmodule

bind line_rasterizer lr_checker #(
   .GRID_SIZE (GRID_SIZE)
) u_lr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
